@@ rtl/core/cfp_pkg.sv @@
// types, token constants and codes shared by the command frame parser
package cfp_pkg;

  // field widths
  localparam int ByteW   = 8;
  localparam int CmdW    = 3;
  localparam int LenW    = 10;
  localparam int CrcW    = 14;
  localparam int StatW   = 3;
  localparam int PosW    = 10;
  localparam int TokPosW = 3;
  localparam int CmdCnt  = 7;

  // largest payload length accepted by the length field
  localparam int MaxLen = 999;

  // byte positions inside the fixed fields
  localparam int TokLast    = 5;
  localparam int LenSemiPos = 3;
  localparam int CrcSemiPos = 4;
  localparam int EndLast    = 2;

  // ascii characters
  localparam logic [ByteW-1:0] ChSemi  = 8'h3B;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;

  // tokens, first character in the top byte
  localparam logic [47:0] StartTok = "START;";
  localparam logic [47:0] EndTok   = {"END", 24'h000000};
  localparam logic [47:0] CmdTok [CmdCnt] = '{
    "SHUTD;", "RESET;", "DCONF;", "CONNC;", "ASYNC;", "UICON;", "SLPOS;"
  };

  // result kinds
  localparam logic KindPay  = 1'b0;
  localparam logic KindStat = 1'b1;

  // status codes
  localparam logic [StatW-1:0] StOk       = 3'd0;
  localparam logic [StatW-1:0] StNoStart  = 3'd1;
  localparam logic [StatW-1:0] StBadCmd   = 3'd2;
  localparam logic [StatW-1:0] StMalform  = 3'd3;
  localparam logic [StatW-1:0] StNoEnd    = 3'd4;

  // parser phase
  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_CMD   = 3'd1,
    PH_LEN   = 3'd2,
    PH_PAY   = 3'd3,
    PH_SEP   = 3'd4,
    PH_CRC   = 3'd5,
    PH_END   = 3'd6
  } phase_e;

  // per-byte compare results handed from the matcher to the parser
  typedef struct packed {
    logic              start_hit;
    logic              end_hit;
    logic [CmdCnt-1:0] cmd_hit;
    logic              is_digit;
    logic              is_semi;
    logic [3:0]        digit;
  } tok_hit_t;

  // character at a position of a six-character token
  function automatic logic [ByteW-1:0] tok_char(input logic [47:0] tok,
                                                input logic [TokPosW-1:0] pos);
    logic [ByteW-1:0] ch;
    case (pos)
      3'd0:    ch = tok[47:40];
      3'd1:    ch = tok[39:32];
      3'd2:    ch = tok[31:24];
      3'd3:    ch = tok[23:16];
      3'd4:    ch = tok[15:8];
      3'd5:    ch = tok[7:0];
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/core/cfp_tok_match.sv @@
// byte compare against start, end and command tokens plus digit decode
module cfp_tok_match (
  input  logic [cfp_pkg::ByteW-1:0]   byte_i,
  input  logic [cfp_pkg::TokPosW-1:0] pos_i,
  output cfp_pkg::tok_hit_t           hit_o
);

  // token compares at the current field position, digit and separator decode
  always_comb begin
    hit_o.start_hit = (byte_i == cfp_pkg::tok_char(cfp_pkg::StartTok, pos_i));
    hit_o.end_hit   = (byte_i == cfp_pkg::tok_char(cfp_pkg::EndTok, pos_i));
    for (int k = 0; k < cfp_pkg::CmdCnt; k++) begin
      hit_o.cmd_hit[k] = (byte_i == cfp_pkg::tok_char(cfp_pkg::CmdTok[k], pos_i));
    end
    hit_o.is_digit = byte_i inside {[cfp_pkg::ChZero:cfp_pkg::ChNine]};
    hit_o.is_semi  = (byte_i == cfp_pkg::ChSemi);
    hit_o.digit    = 4'(byte_i - cfp_pkg::ChZero);
  end

endmodule

@@ rtl/core/command_frame_parser.sv @@
// command frame parser top level: input register, parse step, result register
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, in_byte_i          | to block
//   out     | out_valid_o, out_stall_i, out_kind_o,      | from block
//           | out_byte_o, cmd_id_o, payload_len_o,       |
//           | crc_value_o, status_o                      |
//
// One item per cycle while the output does not stall: a byte is held in the
// input register, is parsed by a single compare or multiply-by-ten step, and its
// result (if any) is then captured in the result register.
// Reset puts the parser in the search for START; no clearing pass is needed.
// A stall on the output holds the result register and, once the input
// register is full, raises in_stall_o in the same cycle.
module command_frame_parser #(
  parameter int MaxLen = cfp_pkg::MaxLen
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [cfp_pkg::ByteW-1:0]  in_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       out_kind_o,
  output logic [cfp_pkg::ByteW-1:0]  out_byte_o,
  output logic [cfp_pkg::CmdW-1:0]   cmd_id_o,
  output logic [cfp_pkg::LenW-1:0]   payload_len_o,
  output logic [cfp_pkg::CrcW-1:0]   crc_value_o,
  output logic [cfp_pkg::StatW-1:0]  status_o
);

  localparam int PosW = cfp_pkg::PosW;
  localparam int LenW = cfp_pkg::LenW;
  localparam int CrcW = cfp_pkg::CrcW;

  // input register
  logic                      in_valid_q;
  logic [cfp_pkg::ByteW-1:0] in_byte_q;
  logic                      advance;
  logic                      step;

  // parser state
  cfp_pkg::phase_e             phase_q, phase_d;
  logic [PosW-1:0]             pos_q, pos_d;
  logic                        tok_ok_q, tok_ok_d;
  logic [cfp_pkg::CmdCnt-1:0]  cmd_match_q, cmd_match_d;
  logic [LenW-1:0]             len_q, len_d;
  logic [CrcW-1:0]             crc_q, crc_d;
  logic                        stopped_q, stopped_d;

  // result of this step
  logic                        res_vld;
  logic                        res_kind;
  logic [cfp_pkg::ByteW-1:0]   res_byte;
  logic [cfp_pkg::CmdW-1:0]    res_cmd;
  logic [LenW-1:0]             res_len;
  logic [CrcW-1:0]             res_crc;
  logic [cfp_pkg::StatW-1:0]   res_st;
  logic                        clear;

  // result register
  logic                        out_valid_q;
  logic                        out_kind_q;
  logic [cfp_pkg::ByteW-1:0]   out_byte_q;
  logic [cfp_pkg::CmdW-1:0]    out_cmd_q;
  logic [LenW-1:0]             out_len_q;
  logic [CrcW-1:0]             out_crc_q;
  logic [cfp_pkg::StatW-1:0]   out_st_q;

  cfp_pkg::tok_hit_t           hit;
  logic [cfp_pkg::CmdW-1:0]    cur_cmd;
  logic                        tok_ok_n;
  logic [cfp_pkg::CmdCnt-1:0]  cmd_match_n;
  logic [LenW-1:0]             pos_inc_len;

  // handshake: the input register moves on when the result register frees up
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= in_byte_i;
    end
  end

  // token and digit compares
  cfp_tok_match u_tok_match (
    .byte_i (in_byte_q),
    .pos_i  (pos_q[cfp_pkg::TokPosW-1:0]),
    .hit_o  (hit)
  );

  // command id: lowest matching command once the command field is past
  always_comb begin
    cur_cmd = '0;
    if (phase_q != cfp_pkg::PH_START && phase_q != cfp_pkg::PH_CMD) begin
      for (int k = cfp_pkg::CmdCnt - 1; k >= 0; k--) begin
        if (cmd_match_q[k]) begin
          cur_cmd = cfp_pkg::CmdW'(k);
        end
      end
    end
  end

  assign tok_ok_n    = tok_ok_q && (phase_q == cfp_pkg::PH_END ? hit.end_hit : hit.start_hit);
  assign cmd_match_n = cmd_match_q & hit.cmd_hit;
  assign pos_inc_len = LenW'(pos_q + PosW'(1));

  // parse step
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    tok_ok_d    = tok_ok_q;
    cmd_match_d = cmd_match_q;
    len_d       = len_q;
    crc_d       = crc_q;
    stopped_d   = stopped_q;
    res_vld     = 1'b0;
    res_kind    = cfp_pkg::KindStat;
    res_byte    = '0;
    res_cmd     = cur_cmd;
    res_len     = len_q;
    res_crc     = crc_q;
    res_st      = cfp_pkg::StOk;
    clear       = 1'b0;
    if (step) begin
      case (phase_q)
        cfp_pkg::PH_START: begin
          tok_ok_d = tok_ok_n;
          if (pos_q >= PosW'(cfp_pkg::TokLast)) begin
            if (!tok_ok_n) begin
              res_vld = 1'b1;
              res_st  = cfp_pkg::StNoStart;
              clear   = 1'b1;
            end else begin
              phase_d     = cfp_pkg::PH_CMD;
              pos_d       = '0;
              cmd_match_d = '1;
            end
          end else begin
            pos_d = pos_q + PosW'(1);
          end
        end
        cfp_pkg::PH_CMD: begin
          cmd_match_d = cmd_match_n;
          if (pos_q >= PosW'(cfp_pkg::TokLast)) begin
            if (cmd_match_n == '0) begin
              res_vld = 1'b1;
              res_st  = cfp_pkg::StBadCmd;
              clear   = 1'b1;
            end else begin
              phase_d   = cfp_pkg::PH_LEN;
              pos_d     = '0;
              len_d     = '0;
              stopped_d = 1'b0;
            end
          end else begin
            pos_d = pos_q + PosW'(1);
          end
        end
        cfp_pkg::PH_LEN: begin
          if (pos_q < PosW'(cfp_pkg::LenSemiPos)) begin
            if (!stopped_q && hit.is_digit) begin
              len_d = LenW'(len_q * LenW'(10) + LenW'(hit.digit));
            end else begin
              stopped_d = 1'b1;
            end
            pos_d = pos_q + PosW'(1);
          end else if (!hit.is_semi || len_q > LenW'(MaxLen)) begin
            res_vld = 1'b1;
            res_st  = cfp_pkg::StMalform;
            clear   = 1'b1;
          end else begin
            phase_d = (len_q != '0) ? cfp_pkg::PH_PAY : cfp_pkg::PH_SEP;
            pos_d   = '0;
          end
        end
        cfp_pkg::PH_PAY: begin
          res_vld  = 1'b1;
          res_kind = cfp_pkg::KindPay;
          res_byte = in_byte_q;
          res_crc  = '0;
          if (pos_inc_len >= len_q) begin
            phase_d = cfp_pkg::PH_SEP;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + PosW'(1);
          end
        end
        cfp_pkg::PH_SEP: begin
          phase_d   = cfp_pkg::PH_CRC;
          pos_d     = '0;
          crc_d     = '0;
          stopped_d = 1'b0;
        end
        cfp_pkg::PH_CRC: begin
          if (pos_q < PosW'(cfp_pkg::CrcSemiPos)) begin
            if (!stopped_q && hit.is_digit) begin
              crc_d = CrcW'(crc_q * CrcW'(10) + CrcW'(hit.digit));
            end else begin
              stopped_d = 1'b1;
            end
            pos_d = pos_q + PosW'(1);
          end else if (!hit.is_semi) begin
            res_vld = 1'b1;
            res_st  = cfp_pkg::StMalform;
            clear   = 1'b1;
          end else begin
            phase_d  = cfp_pkg::PH_END;
            pos_d    = '0;
            tok_ok_d = 1'b1;
          end
        end
        cfp_pkg::PH_END: begin
          tok_ok_d = tok_ok_n;
          if (pos_q >= PosW'(cfp_pkg::EndLast)) begin
            res_vld = 1'b1;
            res_st  = tok_ok_n ? cfp_pkg::StOk : cfp_pkg::StNoEnd;
            clear   = 1'b1;
          end else begin
            pos_d = pos_q + PosW'(1);
          end
        end
        default: begin
          clear = 1'b1;
        end
      endcase
      // frame done: back to searching for START
      if (clear) begin
        phase_d     = cfp_pkg::PH_START;
        pos_d       = '0;
        tok_ok_d    = 1'b1;
        cmd_match_d = '1;
        len_d       = '0;
        crc_d       = '0;
        stopped_d   = 1'b0;
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= cfp_pkg::PH_START;
      pos_q       <= '0;
      tok_ok_q    <= 1'b1;
      cmd_match_q <= '1;
      len_q       <= '0;
      crc_q       <= '0;
      stopped_q   <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      tok_ok_q    <= tok_ok_d;
      cmd_match_q <= cmd_match_d;
      len_q       <= len_d;
      crc_q       <= crc_d;
      stopped_q   <= stopped_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_vld;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance && res_vld) begin
      out_kind_q <= res_kind;
      out_byte_q <= res_byte;
      out_cmd_q  <= res_cmd;
      out_len_q  <= res_len;
      out_crc_q  <= res_crc;
      out_st_q   <= res_st;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_kind_q;
  assign out_byte_o    = out_byte_q;
  assign cmd_id_o      = out_cmd_q;
  assign payload_len_o = out_len_q;
  assign crc_value_o   = out_crc_q;
  assign status_o      = out_st_q;

  // payload items carry no status and no crc
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == cfp_pkg::KindPay
      |-> status_o == cfp_pkg::StOk && crc_value_o == '0)
    else $error("payload item with status or crc set");

  // payload count stays inside the parsed length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == cfp_pkg::PH_PAY |-> len_q != '0 && LenW'(pos_q) < len_q)
    else $error("payload position outside parsed length");

  // exactly one command survives past the command field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == cfp_pkg::PH_LEN || phase_q == cfp_pkg::PH_PAY ||
    phase_q == cfp_pkg::PH_SEP || phase_q == cfp_pkg::PH_CRC ||
    phase_q == cfp_pkg::PH_END |-> $onehot(cmd_match_q))
    else $error("command match not one-hot after command field");

  // a status item sends the parser back to the START search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && res_vld && res_kind == cfp_pkg::KindStat
      |=> phase_q == cfp_pkg::PH_START && pos_q == '0 && out_valid_o)
    else $error("status item without frame restart");

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the command frame parser
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // one result item as seen on the output ports
  typedef struct packed {
    logic                      kind;
    logic [cfp_pkg::ByteW-1:0] data;
    logic [cfp_pkg::CmdW-1:0]  cmd;
    logic [cfp_pkg::LenW-1:0]  len;
    logic [cfp_pkg::CrcW-1:0]  crc;
    logic [cfp_pkg::StatW-1:0] status;
  } frame_result_t;

  // ways a random frame gets broken
  typedef enum int {
    FlawStart, FlawCmd, FlawLenSemi, FlawCrcSemi, FlawEnd, FlawNoise
  } flaw_e;

  // character p of a token, first character in the top byte
  function automatic logic [cfp_pkg::ByteW-1:0] char_at(logic [47:0] tok, int p);
    return tok[47-8*p -: 8];
  endfunction

  // tracks the parser state and holds the results each byte should cause
  class frame_scoreboard;
    frame_result_t            expected_q[$];
    int                       errors;
    cfp_pkg::phase_e          ph;
    int                       pos;
    bit                       tok_ok;
    bit [cfp_pkg::CmdCnt-1:0] match;
    int                       len_acc;
    int                       crc_acc;
    bit                       stopped;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      ph      = cfp_pkg::PH_START;
      pos     = 0;
      tok_ok  = 1'b1;
      match   = '1;
      len_acc = 0;
      crc_acc = 0;
      stopped = 1'b0;
    endfunction

    function logic [cfp_pkg::CmdW-1:0] matched_cmd();
      if (ph == cfp_pkg::PH_START || ph == cfp_pkg::PH_CMD) return '0;
      for (int k = 0; k < cfp_pkg::CmdCnt; k++)
        if (match[k]) return cfp_pkg::CmdW'(k);
      return '0;
    endfunction

    // atoi-style accumulate: the first non-digit freezes the value
    function int accumulate(int acc, logic [cfp_pkg::ByteW-1:0] b);
      if (!stopped && b >= cfp_pkg::ChZero && b <= cfp_pkg::ChNine)
        return acc * 10 + int'(b - cfp_pkg::ChZero);
      stopped = 1'b1;
      return acc;
    endfunction

    // status item ends the frame and resets the parse state
    function void push_status(logic [cfp_pkg::StatW-1:0] st);
      frame_result_t r;
      r.kind   = cfp_pkg::KindStat;
      r.data   = '0;
      r.cmd    = matched_cmd();
      r.len    = cfp_pkg::LenW'(len_acc);
      r.crc    = cfp_pkg::CrcW'(crc_acc);
      r.status = st;
      expected_q.push_back(r);
      clear();
    endfunction

    // advance the parse by one accepted byte
    function void note_byte(logic [cfp_pkg::ByteW-1:0] b);
      frame_result_t r;
      case (ph)
        cfp_pkg::PH_START: begin
          if (pos > cfp_pkg::TokLast || b != char_at(cfp_pkg::StartTok, pos)) tok_ok = 1'b0;
          if (pos >= cfp_pkg::TokLast) begin
            if (!tok_ok) begin
              push_status(cfp_pkg::StNoStart);
            end else begin
              ph    = cfp_pkg::PH_CMD;
              pos   = 0;
              match = '1;
            end
          end else begin
            pos++;
          end
        end
        cfp_pkg::PH_CMD: begin
          for (int k = 0; k < cfp_pkg::CmdCnt; k++)
            if (pos > cfp_pkg::TokLast || b != char_at(cfp_pkg::CmdTok[k], pos))
              match[k] = 1'b0;
          if (pos >= cfp_pkg::TokLast) begin
            if (match == '0) begin
              push_status(cfp_pkg::StBadCmd);
            end else begin
              ph      = cfp_pkg::PH_LEN;
              pos     = 0;
              len_acc = 0;
              stopped = 1'b0;
            end
          end else begin
            pos++;
          end
        end
        cfp_pkg::PH_LEN: begin
          if (pos < cfp_pkg::LenSemiPos) begin
            len_acc = accumulate(len_acc, b);
            pos++;
          end else if (b != cfp_pkg::ChSemi || len_acc > cfp_pkg::MaxLen) begin
            push_status(cfp_pkg::StMalform);
          end else begin
            ph  = (len_acc != 0) ? cfp_pkg::PH_PAY : cfp_pkg::PH_SEP;
            pos = 0;
          end
        end
        cfp_pkg::PH_PAY: begin
          r.kind   = cfp_pkg::KindPay;
          r.data   = b;
          r.cmd    = matched_cmd();
          r.len    = cfp_pkg::LenW'(len_acc);
          r.crc    = '0;
          r.status = cfp_pkg::StOk;
          expected_q.push_back(r);
          pos++;
          if (pos >= len_acc) begin
            ph  = cfp_pkg::PH_SEP;
            pos = 0;
          end
        end
        cfp_pkg::PH_SEP: begin
          ph      = cfp_pkg::PH_CRC;
          pos     = 0;
          crc_acc = 0;
          stopped = 1'b0;
        end
        cfp_pkg::PH_CRC: begin
          if (pos < cfp_pkg::CrcSemiPos) begin
            crc_acc = accumulate(crc_acc, b);
            pos++;
          end else if (b != cfp_pkg::ChSemi) begin
            push_status(cfp_pkg::StMalform);
          end else begin
            ph     = cfp_pkg::PH_END;
            pos    = 0;
            tok_ok = 1'b1;
          end
        end
        default: begin
          if (pos > cfp_pkg::EndLast || b != char_at(cfp_pkg::EndTok, pos)) tok_ok = 1'b0;
          if (pos >= cfp_pkg::EndLast) push_status(tok_ok ? cfp_pkg::StOk : cfp_pkg::StNoEnd);
          else pos++;
        end
      endcase
    endfunction

    // compare one accepted result with the oldest expected one
    function void check_result(frame_result_t got);
      frame_result_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d byte=%h cmd=%0d len=%0d crc=%0d status=%0d",
                 $time, got.kind, got.data, got.cmd, got.len, got.crc, got.status);
        return;
      end
      exp = expected_q.pop_front();
      if (got !== exp) begin
        errors++;
        $display("%0t: mismatch expected kind=%0d byte=%h cmd=%0d len=%0d crc=%0d status=%0d",
                 $time, exp.kind, exp.data, exp.cmd, exp.len, exp.crc, exp.status);
        $display("%0t:          actual   kind=%0d byte=%h cmd=%0d len=%0d crc=%0d status=%0d",
                 $time, got.kind, got.data, got.cmd, got.len, got.crc, got.status);
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic [cfp_pkg::ByteW-1:0] in_byte   = '0;
  logic                      out_stall = 1'b0;
  logic                      in_stall;
  logic                      out_valid;
  logic                      out_kind;
  logic [cfp_pkg::ByteW-1:0] out_byte;
  logic [cfp_pkg::CmdW-1:0]  cmd_id;
  logic [cfp_pkg::LenW-1:0]  payload_len;
  logic [cfp_pkg::CrcW-1:0]  crc_value;
  logic [cfp_pkg::StatW-1:0] status;

  frame_scoreboard           sb = new();
  logic [cfp_pkg::ByteW-1:0] frame_q[$];
  int                        send_idle_pct = 0;
  int                        stall_pct     = 0;
  int                        sent_items    = 0;

  command_frame_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .in_byte_i     (in_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_kind_o    (out_kind),
    .out_byte_o    (out_byte),
    .cmd_id_o      (cmd_id),
    .payload_len_o (payload_len),
    .crc_value_o   (crc_value),
    .status_o      (status)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // random receiver stall
  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_kind, out_byte, cmd_id, payload_len, crc_value, status});
  end

  // one item over the input handshake, with random idle cycles ahead of it
  task automatic send_byte(logic [cfp_pkg::ByteW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk_i); while (in_stall);
    sb.note_byte(b);
    sent_items++;
    @(negedge clk_i);
  endtask

  function automatic logic [cfp_pkg::ByteW-1:0] non_digit();
    logic [cfp_pkg::ByteW-1:0] b;
    if ($urandom_range(2) == 0) return cfp_pkg::ChSemi;
    do b = cfp_pkg::ByteW'($urandom_range(255));
    while (b >= cfp_pkg::ChZero && b <= cfp_pkg::ChNine);
    return b;
  endfunction

  function automatic void add_tok(logic [47:0] tok, int n);
    for (int i = 0; i < n; i++) frame_q.push_back(char_at(tok, i));
  endfunction

  // digit field of ndig characters plus ';', zero padded or cut short by a non-digit
  function automatic void add_number(int value, int ndig);
    string s;
    int    used;
    s = $sformatf("%0d", value);
    if (value == 0 && $urandom_range(1) == 1) s = "";
    if ($urandom_range(1) == 0 || s.len() >= ndig) begin
      while (s.len() < ndig) s = {"0", s};
      for (int i = 0; i < ndig; i++) frame_q.push_back(s[i]);
    end else begin
      for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
      frame_q.push_back(non_digit());
      used = s.len() + 1;
      while (used < ndig) begin
        frame_q.push_back(cfp_pkg::ByteW'($urandom_range(255)));
        used++;
      end
    end
    frame_q.push_back(cfp_pkg::ChSemi);
  endfunction

  // well-formed frame with random payload and separator
  function automatic void build_frame(int cmd, int len, int crc);
    frame_q.delete();
    add_tok(cfp_pkg::StartTok, 6);
    add_tok(cfp_pkg::CmdTok[cmd], 6);
    add_number(len, cfp_pkg::LenSemiPos);
    repeat (len) frame_q.push_back(cfp_pkg::ByteW'($urandom_range(255)));
    frame_q.push_back(cfp_pkg::ByteW'($urandom_range(255)));
    add_number(crc, cfp_pkg::CrcSemiPos);
    add_tok(cfp_pkg::EndTok, 3);
  endfunction

  task automatic send_frame_bytes(int cut);
    for (int i = 0; i < cut; i++) send_byte(frame_q[i]);
  endtask

  task automatic send_good(int cmd, int len, int crc);
    build_frame(cmd, len, crc);
    send_frame_bytes(frame_q.size());
  endtask

  // broken frame, cut at the end of the field that fails so the search stays aligned
  task automatic send_broken(flaw_e flaw, int len);
    int cut;
    int at;
    build_frame($urandom_range(cfp_pkg::CmdCnt-1), len, $urandom_range(9999));
    at = -1;
    case (flaw)
      FlawStart: begin
        at  = $urandom_range(cfp_pkg::TokLast);
        cut = 6;
      end
      FlawCmd: begin
        at  = 6 + $urandom_range(cfp_pkg::TokLast);
        cut = 12;
      end
      FlawLenSemi: begin
        at  = 15;
        cut = 16;
      end
      FlawCrcSemi: begin
        at  = 21 + len;
        cut = 22 + len;
      end
      FlawEnd: begin
        at  = 22 + len + $urandom_range(cfp_pkg::EndLast);
        cut = 25 + len;
      end
      default: begin
        frame_q.delete();
        cut = 6 * $urandom_range(1, 2);
        repeat (cut) frame_q.push_back(cfp_pkg::ByteW'($urandom_range(255)));
      end
    endcase
    if (at >= 0) frame_q[at] = frame_q[at] ^ cfp_pkg::ByteW'($urandom_range(1, 255));
    send_frame_bytes(cut);
  endtask

  task automatic send_random_frame();
    int len;
    len = ($urandom_range(49) == 0) ? $urandom_range(60) : $urandom_range(8);
    if ($urandom_range(99) < 80)
      send_good($urandom_range(cfp_pkg::CmdCnt-1), len, $urandom_range(9999));
    else
      send_broken(flaw_e'($urandom_range(5)), len);
  endtask

  // main sequence
  initial begin
    int target;
    int directed_items;
    repeat (10) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // directed: every command, zero and longest payload, largest crc, each error
    send_idle_pct = 20;
    stall_pct     = 58;
    for (int c = 0; c < cfp_pkg::CmdCnt; c++) send_good(c, c, $urandom_range(9999));
    send_good(0, 0, 0);
    send_good($urandom_range(cfp_pkg::CmdCnt-1), cfp_pkg::MaxLen, 9999);
    for (int f = FlawStart; f <= FlawNoise; f++) send_broken(flaw_e'(f), $urandom_range(3));
    directed_items = sent_items;

    // random frames under three idle patterns
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_idle_pct = 20; stall_pct = 58; end
        1: begin send_idle_pct = 58; stall_pct = 20; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      target = directed_items + (p + 1) * 220;
      while (sent_items < target) send_random_frame();
    end
    in_valid <= 1'b0;

    // drain outstanding results
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
